>>> rtl/interleaver_address_generator_defines.svh
// ----------------------------------------------------------------------------
// Interleaver address generator assertion macros
// Shared property forms for the checker of the address generator.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVER_ADDRESS_GENERATOR_DEFINES_SVH
`define INTERLEAVER_ADDRESS_GENERATOR_DEFINES_SVH

// same-cycle implication, muted during reset
`define IAG_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted during reset
`define IAG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/iag_pkg.sv
// ----------------------------------------------------------------------------
// Interleaver address generator package
// Widths, status codes and the divider command shared by the block's files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iag_pkg;

   // field widths
   localparam int LEN_W    = 14;
   localparam int POS_W    = 13;
   localparam int ALPHA_W  = 7;
   localparam int STATUS_W = 2;

   // candidate counter reaches one past the largest alpha
   localparam int CAND_W = ALPHA_W + 1;
   localparam int SQ_W   = 2 * CAND_W;

   // divider datapath: alpha * position + beta fits in 20 bits
   localparam int DIV_W       = ALPHA_W + POS_W;
   localparam int STEP_W      = 4;
   localparam int SHORT_STEPS = ALPHA_W;
   localparam int LONG_STEPS  = POS_W;
   localparam int SHORT_SHIFT = SHORT_STEPS - 1;
   localparam int LONG_SHIFT  = LONG_STEPS - 1;

   // defaults
   localparam int DEFAULT_MAX_LENGTH = 8192;
   localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(1024);
   localparam logic [CAND_W-1:0] FIRST_CAND  = CAND_W'(3);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ALPHA = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   // divider command
   typedef struct packed {
      logic start;
      logic short_mode;
   } div_cmd_type;

endpackage

`default_nettype wire

>>> rtl/iag_div.sv
// ----------------------------------------------------------------------------
// Interleaver remainder unit
// Restoring remainder, one quotient bit per cycle. Short mode resolves a
// 7-bit quotient, long mode a 13-bit quotient on a divisor below 128.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iag_div (
   input  wire                       clock,
   input  wire                       reset,
   input  iag_pkg::div_cmd_type      cmd,
   input  wire [iag_pkg::DIV_W-1:0]  dividend,
   input  wire [iag_pkg::LEN_W-1:0]  divisor,
   output logic                      done,
   output logic [iag_pkg::DIV_W-1:0] remainder
);
   import iag_pkg::*;

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsh_ff, dsh_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   // load on start, then one compare and subtract per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in = dividend;
         run_in = 1'b1;
         if (cmd.short_mode) begin
            dsh_in = DIV_W'(divisor) << SHORT_SHIFT;
            cnt_in = STEP_W'(SHORT_STEPS);
         end else begin
            dsh_in = DIV_W'(divisor[ALPHA_W-1:0]) << LONG_SHIFT;
            cnt_in = STEP_W'(LONG_STEPS);
         end
      end else if (run_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/interleaver_address_generator.sv
// ----------------------------------------------------------------------------
// Interleaver address generator
// Linear permutation interleaver: address = (alpha*position + beta) mod n.
// ----------------------------------------------------------------------------
// One position is handled at a time. With the multiplier already derived for
// the current block length, each position takes one 7-step remainder pass
// that reduces alpha*position+beta modulo n. After the length register
// changes, the first position also runs the multiplier search: every
// candidate alpha below sqrt(n) costs a 13-step remainder of n by alpha - 1,
// and candidates for which alpha - 1 divides n add a short Euclid chain.
// The search result is cached until the length changes again. The result
// register lets the next position be taken while a result still waits.
`timescale 1ns / 1ps
`default_nettype none

module interleaver_address_generator #(
   parameter int MAX_LENGTH = iag_pkg::DEFAULT_MAX_LENGTH
) (
   input  wire                          clock,
   input  wire                          reset,
   // configuration
   input  wire                          csr_wr_en,
   input  wire [iag_pkg::LEN_W-1:0]     csr_wr_data,
   // request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [iag_pkg::POS_W-1:0]     req_position,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [iag_pkg::POS_W-1:0]    rsp_address,
   output logic [iag_pkg::ALPHA_W-1:0]  rsp_multiplier,
   output logic [iag_pkg::STATUS_W-1:0] rsp_status
);
   import iag_pkg::*;

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CAND = 3'd1;
   localparam logic [2:0] ST_DIVM = 3'd2;
   localparam logic [2:0] ST_GCD  = 3'd3;
   localparam logic [2:0] ST_MAP  = 3'd4;
   localparam logic [2:0] ST_PROD = 3'd5;
   localparam logic [2:0] ST_MOD  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    dlen_ff, dlen_in;
   logic [ALPHA_W-1:0]  dalpha_ff, dalpha_in;
   logic [LEN_W-1:0]    n_ff, n_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CAND_W-1:0]   cand_ff, cand_in;
   logic [ALPHA_W-1:0]  best_ff, best_in;
   logic [ALPHA_W-1:0]  gx_ff, gx_in;
   logic [DIV_W-1:0]    prod_ff, prod_in;
   logic [POS_W-1:0]    res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_address_ff, rsp_address_in;
   logic [ALPHA_W-1:0]  rsp_multiplier_ff, rsp_multiplier_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [LEN_W-1:0]    n_eff;
   logic [SQ_W-1:0]     cand_sq;
   logic [ALPHA_W-1:0]  beta;
   div_cmd_type         div_cmd;
   logic [DIV_W-1:0]    div_dividend;
   logic [LEN_W-1:0]    div_divisor;
   logic                div_done;
   logic [DIV_W-1:0]    div_rem;

   // effective length, saturated to the largest supported block
   always_comb begin
      n_eff = len_ff;
      if (17'(len_ff) > 17'(MAX_LENGTH)) begin
         n_eff = LEN_W'(MAX_LENGTH);
      end
   end

   assign cand_sq   = SQ_W'(cand_ff) * SQ_W'(cand_ff);
   assign beta      = (dalpha_ff - ALPHA_W'(1)) >> 1;
   assign req_ready = (state_ff == ST_IDLE);
   assign len_in    = csr_wr_en ? csr_wr_data : len_ff;

   // sequencer: multiplier search on a length change, then one reduction per position in range
   always_comb begin
      state_in          = state_ff;
      dlen_in           = dlen_ff;
      dalpha_in         = dalpha_ff;
      n_in              = n_ff;
      pos_in            = pos_ff;
      cand_in           = cand_ff;
      best_in           = best_ff;
      gx_in             = gx_ff;
      prod_in           = prod_ff;
      res_addr_in       = res_addr_ff;
      res_status_in     = res_status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_address_in    = rsp_address_ff;
      rsp_multiplier_in = rsp_multiplier_ff;
      rsp_status_in     = rsp_status_ff;
      div_cmd           = '0;
      div_dividend      = DIV_W'(n_ff);
      div_divisor       = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in   = n_eff;
               pos_in = req_position;
               if (n_eff != dlen_ff || n_eff == '0) begin
                  cand_in  = FIRST_CAND;
                  best_in  = '0;
                  state_in = ST_CAND;
               end else begin
                  state_in = ST_MAP;
               end
            end
         end
         ST_CAND: begin
            if (cand_sq >= SQ_W'(n_ff)) begin
               dalpha_in = best_ff;
               dlen_in   = n_ff;
               state_in  = ST_MAP;
            end else begin
               // does (alpha - 1) divide n
               div_cmd.start = 1'b1;
               div_divisor   = LEN_W'(cand_ff - CAND_W'(1));
               state_in      = ST_DIVM;
            end
         end
         ST_DIVM: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  // first Euclid step: n mod alpha
                  div_cmd.start = 1'b1;
                  div_divisor   = LEN_W'(cand_ff);
                  gx_in         = cand_ff[ALPHA_W-1:0];
                  state_in      = ST_GCD;
               end else begin
                  cand_in  = cand_ff + CAND_W'(1);
                  state_in = ST_CAND;
               end
            end
         end
         ST_GCD: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  if (gx_ff == ALPHA_W'(1)) begin
                     best_in = cand_ff[ALPHA_W-1:0];
                  end
                  cand_in  = cand_ff + CAND_W'(1);
                  state_in = ST_CAND;
               end else begin
                  // remaining Euclid steps on values below 128
                  div_cmd.start      = 1'b1;
                  div_cmd.short_mode = 1'b1;
                  div_dividend       = DIV_W'(gx_ff);
                  div_divisor        = LEN_W'(div_rem[ALPHA_W-1:0]);
                  gx_in              = div_rem[ALPHA_W-1:0];
               end
            end
         end
         ST_MAP: begin
            res_addr_in = '0;
            if (dalpha_ff == '0) begin
               res_status_in = STATUS_NO_ALPHA;
               state_in      = ST_DONE;
            end else if (LEN_W'(pos_ff) >= n_ff) begin
               res_status_in = STATUS_RANGE;
               state_in      = ST_DONE;
            end else begin
               res_status_in = STATUS_OK;
               prod_in       = DIV_W'(dalpha_ff) * DIV_W'(pos_ff) + DIV_W'(beta);
               state_in      = ST_PROD;
            end
         end
         ST_PROD: begin
            div_cmd.start      = 1'b1;
            div_cmd.short_mode = 1'b1;
            div_dividend       = prod_ff;
            state_in           = ST_MOD;
         end
         ST_MOD: begin
            if (div_done) begin
               res_addr_in = div_rem[POS_W-1:0];
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the result register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_address_in    = res_addr_ff;
               rsp_multiplier_in = dalpha_ff;
               rsp_status_in     = res_status_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= RESET_LENGTH;
         dlen_ff      <= '0;
         dalpha_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         dlen_ff      <= dlen_in;
         dalpha_ff    <= dalpha_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      n_ff              <= n_in;
      pos_ff            <= pos_in;
      cand_ff           <= cand_in;
      best_ff           <= best_in;
      gx_ff             <= gx_in;
      prod_ff           <= prod_in;
      res_addr_ff       <= res_addr_in;
      res_status_ff     <= res_status_in;
      rsp_address_ff    <= rsp_address_in;
      rsp_multiplier_ff <= rsp_multiplier_in;
      rsp_status_ff     <= rsp_status_in;
   end

   // shared remainder unit
   iag_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_multiplier = rsp_multiplier_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/iag_checker.sv
// ----------------------------------------------------------------------------
// Interleaver address generator checker
// Port-level properties of the address generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "interleaver_address_generator_defines.svh"

module iag_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [iag_pkg::POS_W-1:0]     rsp_address,
   input wire [iag_pkg::ALPHA_W-1:0]   rsp_multiplier,
   input wire [iag_pkg::STATUS_W-1:0]  rsp_status
);
   import iag_pkg::*;

   // a missing multiplier gives a zero address and a zero multiplier
   `IAG_ASSERT_IMPLY(a_no_alpha_zero, clock, reset, rsp_valid && rsp_status == STATUS_NO_ALPHA, rsp_address == '0 && rsp_multiplier == '0, "no-alpha result not zeroed")

   // an out-of-range position still reports the multiplier
   `IAG_ASSERT_IMPLY(a_range_fields, clock, reset, rsp_valid && rsp_status == STATUS_RANGE, rsp_address == '0 && rsp_multiplier != '0, "range result fields wrong")

   // a good result always comes from a multiplier of at least three
   `IAG_ASSERT_IMPLY(a_ok_alpha, clock, reset, rsp_valid && rsp_status == STATUS_OK, rsp_multiplier >= ALPHA_W'(3), "ok result with bad multiplier")

   // the block works on one position at a time
   `IAG_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready right after a request transfer")

   // a stalled response holds its address and status
   `IAG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_address) && $stable(rsp_status), "stalled response changed")

endmodule

bind interleaver_address_generator iag_checker u_iag_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_address    (rsp_address),
   .rsp_multiplier (rsp_multiplier),
   .rsp_status     (rsp_status)
);

`default_nettype wire
